// ===== rtl/sfur_pkg.sv =====
// Shared types, constants and CRC byte functions for the firmware update receiver.
// No dependencies.
package sfur_pkg;

    localparam logic [7:0] SYNC_CODE = 8'h7F;
    localparam logic [7:0] CMD_BEGIN = 8'h01;
    localparam logic [7:0] CMD_CHUNK = 8'h02;
    localparam logic [7:0] CMD_CHECK = 8'h03;
    localparam logic       REPLY_ACK  = 1'b0;
    localparam logic       REPLY_NACK = 1'b1;

    localparam logic [2:0] REG_MAX_IMAGE  = 3'd0;
    localparam logic [2:0] REG_MAX_CHUNK  = 3'd1;
    localparam logic [2:0] REG_HDR_TMO    = 3'd2;
    localparam logic [2:0] REG_PKT_TMO    = 3'd3;
    localparam logic [2:0] REG_DATA_TMO   = 3'd4;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_HEADER = 3'd1,
        PH_PKTHDR = 3'd2,
        PH_DATA   = 3'd3,
        PH_CRC    = 3'd4,
        PH_VERIFY = 3'd5
    } phase_t;

    // Classified input word handed from front to back
    typedef struct packed {
        logic       is_tick;
        logic [7:0] rx_byte;
        logic       is_sync;
        logic       is_begin;
        logic       is_chunk;
        logic       is_check;
    } word_t;

    typedef struct packed {
        logic        reply_valid;
        logic        reply_code;
        logic        erase_valid;
        logic [16:0] erase_length;
        logic        data_valid;
        logic [16:0] data_offset;
        logic [7:0]  data_value;
        logic        chunk_commit;
        logic        chunk_discard;
        logic        update_done;
        logic        update_failed;
    } result_t;

    function automatic logic [15:0] crc16_byte(input logic [15:0] c_in, input logic [7:0] b);
        logic [15:0] c;
        c = c_in ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
            c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
        return c;
    endfunction

    function automatic logic [31:0] crc32_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'h0, b};
        for (int i = 0; i < 8; i++)
            c = c[0] ? ((c >> 1) ^ 32'hEDB88320) : (c >> 1);
        return c;
    endfunction

endpackage

// ===== rtl/sfur_if.sv =====
// Valid/ready channel interfaces for input and result words.
// No dependencies.
interface sfur_in_if;
    logic       valid;
    logic       ready;
    logic       operation;
    logic [7:0] rx_byte;
    modport source (output valid, operation, rx_byte, input ready);
    modport sink   (input valid, operation, rx_byte, output ready);
endinterface

interface sfur_out_if;
    logic        valid;
    logic        ready;
    logic        reply_valid;
    logic        reply_code;
    logic        erase_valid;
    logic [16:0] erase_length;
    logic        data_valid;
    logic [16:0] data_offset;
    logic [7:0]  data_value;
    logic        chunk_commit;
    logic        chunk_discard;
    logic        update_done;
    logic        update_failed;
    modport source (output valid, reply_valid, reply_code, erase_valid, erase_length,
                    data_valid, data_offset, data_value, chunk_commit, chunk_discard,
                    update_done, update_failed, input ready);
    modport sink   (input valid, reply_valid, reply_code, erase_valid, erase_length,
                    data_valid, data_offset, data_value, chunk_commit, chunk_discard,
                    update_done, update_failed, output ready);
endinterface

// ===== rtl/sfur_front.sv =====
// Front end: accept input words, decode command bytes, push into a two-entry queue.
// Depends on sfur_pkg.
module sfur_front
    import sfur_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  logic  in_operation,
    input  logic [7:0] in_byte,
    output logic  q_valid,
    input  logic  q_pop,
    output word_t q_word
);
    word_t       mem_reg [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        push;
    word_t       w;

    // Classify the byte
    always_comb
    begin
        w.is_tick  = in_operation;
        w.rx_byte  = in_byte;
        w.is_sync  = (in_byte == SYNC_CODE);
        w.is_begin = (in_byte == CMD_BEGIN);
        w.is_chunk = (in_byte == CMD_CHUNK);
        w.is_check = (in_byte == CMD_CHECK);
    end

    assign in_ready = (count_reg != 2'd2);
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_word   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= w;
    end

    // Advance queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (q_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, q_pop};
        end
    end
endmodule

// ===== rtl/sfur_back.sv =====
// Back end: session state machine, CRC units and registered result word.
// Depends on sfur_pkg.
module sfur_back
    import sfur_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    output logic        q_pop,
    input  word_t       q_word,
    input  logic [16:0] max_image_bytes,
    input  logic [8:0]  max_chunk_bytes,
    input  logic [15:0] header_timeout_ticks,
    input  logic [15:0] packet_timeout_ticks,
    input  logic [15:0] data_timeout_ticks,
    output logic        out_valid,
    input  logic        out_ready,
    output result_t     out_res
);
    phase_t      phase_reg, phase_next;
    logic [3:0]  fc_reg, fc_next;
    logic [31:0] size_reg, size_next;
    logic [31:0] exp_reg, exp_next;
    logic [16:0] bc_reg, bc_next;
    logic [15:0] clen_reg, clen_next;
    logic [8:0]  cidx_reg, cidx_next;
    logic [15:0] pcrc_reg, pcrc_next;
    logic [7:0]  plow_reg, plow_next;
    logic [31:0] icc_reg, icc_next;
    logic [31:0] icp_reg, icp_next;
    logic [15:0] tick_reg, tick_next;
    logic        ov_reg;
    result_t     res_reg, r;

    logic [15:0] crc16_n, tick_inc, limit, rx_crc;
    logic [31:0] crc32_n, off32, sum32;
    logic [7:0]  b;
    logic [8:0]  cidx_inc;

    assign q_pop     = q_valid && (!ov_reg || out_ready);
    assign out_valid = ov_reg;
    assign out_res   = res_reg;

    assign b        = q_word.rx_byte;
    assign crc16_n  = crc16_byte(pcrc_reg, b);
    assign crc32_n  = crc32_byte(icp_reg, b);
    assign tick_inc = (tick_reg == 16'hFFFF) ? tick_reg : tick_reg + 16'd1;
    assign off32    = {15'd0, bc_reg} + {23'd0, cidx_reg};
    assign sum32    = {15'd0, bc_reg} + {16'd0, clen_reg};
    assign rx_crc   = {b, plow_reg};
    assign cidx_inc = cidx_reg + 9'd1;

    always_comb
    begin
        unique case (phase_reg)
            PH_HEADER: limit = header_timeout_ticks;
            PH_PKTHDR: limit = packet_timeout_ticks;
            default:   limit = data_timeout_ticks;
        endcase
    end

    // Next state and result word
    always_comb
    begin
        phase_next = phase_reg; fc_next = fc_reg; size_next = size_reg; exp_next = exp_reg;
        bc_next = bc_reg; clen_next = clen_reg; cidx_next = cidx_reg; pcrc_next = pcrc_reg;
        plow_next = plow_reg; icc_next = icc_reg; icp_next = icp_reg; tick_next = tick_reg;
        r = '0;
        if (q_word.is_tick)
        begin
            if (phase_reg != PH_IDLE)
            begin
                tick_next = tick_inc;
                if (tick_inc >= limit)
                begin
                    r.chunk_discard = (phase_reg == PH_DATA) || (phase_reg == PH_CRC);
                    r.reply_valid = 1'b1; r.reply_code = REPLY_NACK; r.update_failed = 1'b1;
                    phase_next = PH_IDLE; tick_next = '0;
                end
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (q_word.is_sync)
                    begin
                        r.reply_valid = 1'b1; r.reply_code = REPLY_ACK;
                        phase_next = PH_HEADER; tick_next = '0; fc_next = '0;
                        size_next = '0; exp_next = '0; clen_next = '0;
                    end
                end
                PH_HEADER:
                begin
                    if (fc_reg == 4'd0)
                        clen_next = {8'd0, b};
                    else if (fc_reg <= 4'd4)
                        size_next = size_reg | ({24'd0, b} << {fc_reg[1:0] - 2'd1, 3'b000});
                    else
                        exp_next = exp_reg | ({24'd0, b} << {fc_reg[1:0] - 2'd1, 3'b000});
                    fc_next = fc_reg + 4'd1;
                    if (fc_reg == 4'd8)
                    begin
                        r.reply_valid = 1'b1;
                        if (clen_reg != {8'd0, CMD_BEGIN} || size_reg == '0
                            || size_reg > {15'd0, max_image_bytes})
                        begin
                            r.reply_code = REPLY_NACK; r.update_failed = 1'b1;
                            phase_next = PH_IDLE; tick_next = '0;
                        end
                        else
                        begin
                            r.reply_code = REPLY_ACK; r.erase_valid = 1'b1;
                            r.erase_length = size_reg[16:0];
                            bc_next = '0; icc_next = '1; icp_next = '1;
                            phase_next = PH_PKTHDR; tick_next = '0; fc_next = '0;
                            clen_next = '0; cidx_next = '0; pcrc_next = '1; plow_next = '0;
                        end
                    end
                end
                PH_PKTHDR:
                begin
                    pcrc_next = crc16_n;
                    fc_next = fc_reg + 4'd1;
                    if (fc_reg == 4'd0)
                        plow_next = b;
                    else if (fc_reg == 4'd1)
                        clen_next = {8'd0, b};
                    else
                    begin
                        clen_next = {b, clen_reg[7:0]};
                        if (plow_reg != CMD_CHUNK || clen_next == '0
                            || clen_next > {7'd0, max_chunk_bytes})
                        begin
                            r.reply_valid = 1'b1; r.reply_code = REPLY_NACK;
                            r.update_failed = 1'b1; phase_next = PH_IDLE; tick_next = '0;
                        end
                        else
                        begin
                            phase_next = PH_DATA; tick_next = '0;
                            cidx_next = '0; icp_next = icc_reg;
                        end
                    end
                end
                PH_DATA:
                begin
                    pcrc_next = crc16_n;
                    r.data_valid = 1'b1; r.data_offset = off32[16:0]; r.data_value = b;
                    if (off32 < size_reg)
                        icp_next = crc32_n;
                    cidx_next = cidx_inc;
                    if ({7'd0, cidx_inc} >= clen_reg)
                    begin
                        phase_next = PH_CRC; tick_next = '0; fc_next = '0;
                    end
                end
                PH_CRC:
                begin
                    if (fc_reg == 4'd0)
                    begin
                        plow_next = b; fc_next = 4'd1;
                    end
                    else
                    begin
                        r.reply_valid = 1'b1;
                        if (rx_crc != pcrc_reg)
                        begin
                            r.reply_code = REPLY_NACK; r.chunk_discard = 1'b1;
                            phase_next = PH_PKTHDR; tick_next = '0; fc_next = '0;
                            clen_next = '0; cidx_next = '0; pcrc_next = '1; plow_next = '0;
                        end
                        else
                        begin
                            r.reply_code = REPLY_ACK; r.chunk_commit = 1'b1;
                            icc_next = icp_reg;
                            bc_next = (sum32 > size_reg) ? size_reg[16:0] : sum32[16:0];
                            tick_next = '0;
                            if ({15'd0, bc_next} >= size_reg)
                                phase_next = PH_VERIFY;
                            else
                            begin
                                phase_next = PH_PKTHDR; fc_next = '0; clen_next = '0;
                                cidx_next = '0; pcrc_next = '1; plow_next = '0;
                            end
                        end
                    end
                end
                PH_VERIFY:
                begin
                    r.reply_valid = 1'b1;
                    phase_next = PH_IDLE; tick_next = '0;
                    if (q_word.is_check && ~icc_reg == exp_reg)
                    begin
                        r.reply_code = REPLY_ACK; r.update_done = 1'b1;
                    end
                    else
                    begin
                        r.reply_code = REPLY_NACK; r.update_failed = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE; tick_next = '0;
                end
            endcase
        end
    end

    // Hold result payload
    always_ff @(posedge clk)
    begin
        if (q_pop)
            res_reg <= r;
    end

    // Advance session state on each popped word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE; fc_reg <= '0; size_reg <= '0; exp_reg <= '0;
            bc_reg <= '0; clen_reg <= '0; cidx_reg <= '0; pcrc_reg <= '1;
            plow_reg <= '0; icc_reg <= '1; icp_reg <= '1; tick_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                phase_reg <= phase_next; fc_reg <= fc_next; size_reg <= size_next;
                exp_reg <= exp_next; bc_reg <= bc_next; clen_reg <= clen_next;
                cidx_reg <= cidx_next; pcrc_reg <= pcrc_next; plow_reg <= plow_next;
                icc_reg <= icc_next; icp_reg <= icp_next; tick_reg <= tick_next;
                ov_reg <= 1'b1;
            end
            else if (out_ready)
                ov_reg <= 1'b0;
        end
    end
endmodule

// ===== rtl/serial_firmware_update_receiver_core.sv =====
// Serial firmware update receiver: one result word for every input word (byte or
// millisecond tick). Sustains one word per clock while out_ch.ready stays high;
// each word passes through the two-entry classify queue and the state machine's
// result register. Configuration is written through cfg_we/cfg_index/cfg_data.
// Depends on sfur_pkg, sfur_if, sfur_front, sfur_back.
module serial_firmware_update_receiver_core
    import sfur_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    sfur_in_if.sink     in_ch,
    sfur_out_if.source  out_ch,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [16:0] cfg_data
);
    logic [16:0] max_image_reg;
    logic [8:0]  max_chunk_reg;
    logic [15:0] hdr_tmo_reg, pkt_tmo_reg, data_tmo_reg;
    logic        q_valid, q_pop;
    word_t       q_word;
    result_t     res;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_image_reg <= 17'd110592;
            max_chunk_reg <= 9'd256;
            hdr_tmo_reg   <= 16'd30000;
            pkt_tmo_reg   <= 16'd10000;
            data_tmo_reg  <= 16'd5000;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MAX_IMAGE: max_image_reg <= cfg_data;
                REG_MAX_CHUNK: max_chunk_reg <= cfg_data[8:0];
                REG_HDR_TMO:   hdr_tmo_reg   <= cfg_data[15:0];
                REG_PKT_TMO:   pkt_tmo_reg   <= cfg_data[15:0];
                REG_DATA_TMO:  data_tmo_reg  <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    sfur_front u_front (
        .clk, .rst_n,
        .in_valid(in_ch.valid), .in_ready(in_ch.ready),
        .in_operation(in_ch.operation), .in_byte(in_ch.rx_byte),
        .q_valid, .q_pop, .q_word
    );

    sfur_back u_back (
        .clk, .rst_n, .q_valid, .q_pop, .q_word,
        .max_image_bytes(max_image_reg), .max_chunk_bytes(max_chunk_reg),
        .header_timeout_ticks(hdr_tmo_reg), .packet_timeout_ticks(pkt_tmo_reg),
        .data_timeout_ticks(data_tmo_reg),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_res(res)
    );

    assign out_ch.reply_valid   = res.reply_valid;
    assign out_ch.reply_code    = res.reply_code;
    assign out_ch.erase_valid   = res.erase_valid;
    assign out_ch.erase_length  = res.erase_length;
    assign out_ch.data_valid    = res.data_valid;
    assign out_ch.data_offset   = res.data_offset;
    assign out_ch.data_value    = res.data_value;
    assign out_ch.chunk_commit  = res.chunk_commit;
    assign out_ch.chunk_discard = res.chunk_discard;
    assign out_ch.update_done   = res.update_done;
    assign out_ch.update_failed = res.update_failed;
endmodule
